// ----- sv/nsf_pkg.sv -----
// Shared types, character codes and prefix classification for the NMEA sentence framer.
package nsf_pkg;

  localparam int LINE_BUFFER_SIZE = 128;
  localparam int FRAMES_PER_EVENT = 2;
  localparam int PREFIX_LEN       = 6;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_D      = 8'h44;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_M      = 8'h4d;
  localparam logic [7:0] CHAR_N      = 8'h4e;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_X      = 8'h58;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_RMC   = 3'd1;
  localparam logic [2:0] KIND_GGA   = 3'd2;
  localparam logic [2:0] KIND_GSV   = 3'd3;
  localparam logic [2:0] KIND_TXT   = 3'd4;

  localparam logic [1:0] TALKER_GP   = 2'd0;
  localparam logic [1:0] TALKER_GN   = 2'd1;
  localparam logic [1:0] TALKER_BD   = 2'd2;
  localparam logic [1:0] TALKER_NONE = 2'd3;

  localparam int BUSY_RMC = 0;
  localparam int BUSY_GGA = 1;
  localparam int BUSY_GSV = 2;

  // Line classified by the front end, waiting for the back end.
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] talker;
    logic [7:0] length;
    logic [2:0] busy;
  } line_item_t;

  // Finished result word.
  typedef struct packed {
    logic [2:0] sentence_kind;
    logic [1:0] talker_kind;
    logic [7:0] line_length;
    logic       captured;
    logic       status_update;
    logic       gps_in_use;
    logic       beidou_in_use;
    logic       parse_event;
  } result_t;

  function automatic logic [1:0] talker_of(logic [7:0] c1, logic [7:0] c2);
    logic [1:0] t;
    t = TALKER_NONE;
    if (c1 == CHAR_G && c2 == CHAR_P) t = TALKER_GP;
    else if (c1 == CHAR_G && c2 == CHAR_N) t = TALKER_GN;
    else if (c1 == CHAR_B && c2 == CHAR_D) t = TALKER_BD;
    return t;
  endfunction

  function automatic logic [2:0] kind_of(logic [7:0] c3, logic [7:0] c4, logic [7:0] c5);
    logic [2:0] k;
    k = KIND_OTHER;
    if (c3 == CHAR_R && c4 == CHAR_M && c5 == CHAR_C) k = KIND_RMC;
    else if (c3 == CHAR_G && c4 == CHAR_G && c5 == CHAR_A) k = KIND_GGA;
    else if (c3 == CHAR_G && c4 == CHAR_S && c5 == CHAR_V) k = KIND_GSV;
    else if (c3 == CHAR_T && c4 == CHAR_X && c5 == CHAR_T) k = KIND_TXT;
    return k;
  endfunction

endpackage

// ----- sv/nsf_fifo.sv -----
// Small register-based queue used between the framer stages and at the result side.
module nsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- sv/nsf_front.sv -----
// Front end: line position, kept prefix bytes and sentence classification on line feed.
module nsf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [7:0]             rx_byte,
  input  logic [2:0]             busy,
  output logic                   full,
  output logic                   item_push,
  output nsf_pkg::line_item_t    item,
  input  logic                   item_full
);

  import nsf_pkg::*;

  logic [7:0] line_count;
  logic [7:0] line_count_next;
  logic [7:0] prefix [PREFIX_LEN];
  logic [7:0] prefix_next [PREFIX_LEN];
  logic [7:0] pos;
  logic       accept;
  logic [1:0] talker;
  logic [2:0] kind;

  assign full   = item_full;
  assign accept = push && !item_full;

  always_comb begin
    // A full line wraps to zero; a dollar sign restarts the line.
    if (rx_byte == CHAR_DOLLAR || line_count >= 8'(LINE_BUFFER_SIZE)) begin
      pos = '0;
    end else begin
      pos = line_count;
    end
    line_count_next = pos + 8'd1;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      prefix_next[i] = (pos == 8'(i)) ? rx_byte : prefix[i];
    end
  end

  always_comb begin
    talker = talker_of(prefix_next[1], prefix_next[2]);
    kind   = kind_of(prefix_next[3], prefix_next[4], prefix_next[5]);
    if (prefix_next[0] != CHAR_DOLLAR || talker == TALKER_NONE || kind == KIND_OTHER) begin
      talker = TALKER_NONE;
      kind   = KIND_OTHER;
    end
  end

  assign item_push   = accept && (rx_byte == CHAR_LF);
  assign item.kind   = kind;
  assign item.talker = talker;
  assign item.length = line_count_next;
  assign item.busy   = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      for (int i = 0; i < PREFIX_LEN; i++) begin
        prefix[i] <= '0;
      end
    end else if (accept) begin
      line_count <= line_count_next;
      for (int i = 0; i < PREFIX_LEN; i++) begin
        prefix[i] <= prefix_next[i];
      end
    end
  end

endmodule

// ----- sv/nsf_back.sv -----
// Back end: capture decision, RMC status bits and the captured-frame event counter.
module nsf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_empty,
  input  nsf_pkg::line_item_t item,
  output logic                item_pop,
  output logic                res_push,
  output nsf_pkg::result_t    res,
  input  logic                res_full
);

  import nsf_pkg::*;

  logic [1:0] captured_frames;
  logic [1:0] captured_frames_next;
  logic [1:0] frames_sum;
  logic       cap;
  logic       is_rmc;
  logic       event_hit;

  assign item_pop = !item_empty && !res_full;
  assign res_push = item_pop;
  assign is_rmc   = (item.kind == KIND_RMC);

  always_comb begin
    unique case (item.kind)
      KIND_RMC: cap = !item.busy[BUSY_RMC];
      KIND_GGA: cap = !item.busy[BUSY_GGA];
      KIND_GSV: cap = !item.busy[BUSY_GSV];
      default:  cap = 1'b0;
    endcase
  end

  always_comb begin
    frames_sum = captured_frames;
    if (cap && (item.kind == KIND_RMC || item.kind == KIND_GGA)) begin
      frames_sum = captured_frames + 2'd1;
    end
    event_hit            = (frames_sum >= 2'(FRAMES_PER_EVENT));
    captured_frames_next = event_hit ? 2'd0 : frames_sum;
  end

  assign res.sentence_kind = item.kind;
  assign res.talker_kind   = item.talker;
  assign res.line_length   = item.length;
  assign res.captured      = cap;
  assign res.status_update = cap && is_rmc;
  assign res.gps_in_use    = cap && is_rmc && (item.talker != TALKER_BD);
  assign res.beidou_in_use = cap && is_rmc && (item.talker != TALKER_GP);
  assign res.parse_event   = event_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      captured_frames <= '0;
    end else if (item_pop) begin
      captured_frames <= captured_frames_next;
    end
  end

endmodule

// ----- sv/nmea_sentence_framer_core.sv -----
// Top level of the NMEA 0183 sentence framer: front end, line queue, back end, result queue.
//
//   channel   direction  handshake                 words
//   input     in         push / full               rx_byte + three store busy flags
//   result    out        empty / pop               one word per line feed byte
//
// One byte is accepted every cycle while full is low. A line feed byte produces
// its result word once it has passed through the line queue and then the result
// queue, each of which holds it in registers; other bytes produce no word.
// Reset clears the line position, the kept prefix bytes, the captured-frame
// counter and both queues. A stall on pop fills the result queue, then the line
// queue, and only then raises full, which holds every byte until a line slot frees.
module nmea_sentence_framer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       rmc_store_busy,
  input  logic       gga_store_busy,
  input  logic       gsv_store_busy,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] sentence_kind,
  output logic [1:0] talker_kind,
  output logic [7:0] line_length,
  output logic       captured,
  output logic       status_update,
  output logic       gps_in_use,
  output logic       beidou_in_use,
  output logic       parse_event
);

  import nsf_pkg::*;

  // Front end to line queue.
  logic       item_push;
  line_item_t item_in;
  logic       item_full;
  // Line queue to back end.
  logic       item_pop;
  line_item_t item_out;
  logic       item_empty;
  // Back end to result queue.
  logic       res_push;
  result_t    res_in;
  logic       res_full;
  result_t    res_out;

  // Track line position and classify each finished line.
  nsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .busy      ({gsv_store_busy, gga_store_busy, rmc_store_busy}),
    .full      (full),
    .item_push (item_push),
    .item      (item_in),
    .item_full (item_full)
  );

  // Hold classified lines so the front end keeps taking bytes during a stall.
  nsf_fifo #(
    .WIDTH ($bits(line_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_line_q (
    .clk   (clk),
    .rst   (rst),
    .push  (item_push),
    .wdata (item_in),
    .full  (item_full),
    .pop   (item_pop),
    .rdata (item_out),
    .empty (item_empty)
  );

  // Decide capture, status bits and parse events in line order.
  nsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_empty (item_empty),
    .item       (item_out),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res_in),
    .res_full   (res_full)
  );

  // Present finished words; pop drains them oldest first.
  nsf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign sentence_kind = res_out.sentence_kind;
  assign talker_kind   = res_out.talker_kind;
  assign line_length   = res_out.line_length;
  assign captured      = res_out.captured;
  assign status_update = res_out.status_update;
  assign gps_in_use    = res_out.gps_in_use;
  assign beidou_in_use = res_out.beidou_in_use;
  assign parse_event   = res_out.parse_event;

endmodule
